/* rtl/tfr_pkg.sv */
// ---------------------------------------------------------------------------
// Terminated frame receiver package
// Shared types and constants for the receiver core and its sub-blocks.
// ---------------------------------------------------------------------------
package tfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned IDLE_W   = 24;
  localparam int unsigned RETRY_W  = 8;
  localparam int unsigned TLEN_W   = 4;
  localparam int unsigned TERM_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_BYTES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 3'd4;

  // Input kind carried on the slave-side tuser.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IN_FRAME = 3'd0,
    ST_TERM     = 3'd1,
    ST_FULL     = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_DISCONN  = 3'd4,
    ST_NO_TERM  = 3'd5
  } status_t;

  typedef struct packed {
    status_t            status;
    logic               last;
    logic [BYTE_W-1:0]  data;
    logic [POS_W-1:0]   position;
  } result_t;

endpackage

/* rtl/terminated_frame_receiver_core.sv */
// ---------------------------------------------------------------------------
// Terminated frame receiver core
// Frames a serial byte stream on a configurable terminator or a length limit
// and turns idle ticks into read timeouts and disconnection reports.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  s_*       in         tuser = cmd (0 byte, 1 idle tick), tdata = rx_byte
//  m_*       out        tuser = status, tlast = last, tdata = data, position
//  cfg_*     in         write only: cfg_index selects the register, cfg_data
//
//  One input transaction is taken per clock cycle while s_tready is high; its
//  result, if any, goes to the output register, or to the skid entry while the
//  output register is held. The rate rests on the frame and idle counters and
//  on the history cells, which compare all terminator bytes in parallel.
//  A two-entry output stage (register plus skid) lets input continue while a
//  result waits; s_tready falls only when both entries are full.
//  Reset (rst, synchronous) loads the register defaults and clears counters.
//
module terminated_frame_receiver_core
  import tfr_pkg::*;
#(
  parameter int unsigned TERM_MAX = 8   // history cells, 1 to 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Slave side.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] rx_byte
  input  logic [0:0]           s_tuser,   // [0] cmd
  // Master side.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [7:0] data, [23:8] position
  output logic [2:0]           m_tuser,   // [2:0] status
  output logic                 m_tlast,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TERM_W-1:0]    cfg_data
);

  localparam logic [TLEN_W-1:0]  TERM_MAX_L = TLEN_W'(TERM_MAX);
  localparam logic [POS_W-1:0]   POS_SAT    = '1;
  localparam logic [IDLE_W-1:0]  IDLE_SAT   = '1;
  localparam logic [RETRY_W-1:0] RETRY_SAT  = '1;

  // Configuration registers.
  logic [TLEN_W-1:0]  term_len;
  logic [TERM_W-1:0]  term_bytes;
  logic [POS_W-1:0]   max_frame_len;
  logic [IDLE_W-1:0]  timeout_limit;
  logic [RETRY_W-1:0] retry_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_len      <= '0;
      term_bytes    <= '0;
      max_frame_len <= 16'd65535;
      timeout_limit <= 24'd100000;
      retry_limit   <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TERM_LEN:      term_len      <= cfg_data[TLEN_W-1:0];
        REG_TERM_BYTES:    term_bytes    <= cfg_data;
        REG_MAX_FRAME_LEN: max_frame_len <= cfg_data[POS_W-1:0];
        REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[IDLE_W-1:0];
        REG_RETRY_LIMIT:   retry_limit   <= cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Receiver state.
  logic [POS_W-1:0]   frame_count;
  logic [IDLE_W-1:0]  idle_count;
  logic [RETRY_W-1:0] retry_count;
  logic [POS_W-1:0]   frame_count_next;
  logic [IDLE_W-1:0]  idle_count_next;
  logic [RETRY_W-1:0] retry_count_next;

  logic    accept;
  logic    is_byte;
  logic    res_valid;
  logic    buf_ready;
  result_t res;
  result_t out_item;

  assign accept   = s_tvalid && s_tready;
  assign is_byte  = (s_tuser[0] == CMD_BYTE);
  assign s_tready = buf_ready;

  // Terminator length in use, limited to the number of cells.
  logic [TLEN_W-1:0] term_n;
  assign term_n = (term_len > TERM_MAX_L) ? TERM_MAX_L : term_len;

  // Row of history cells. Cell 0 takes the incoming byte; each later cell
  // takes what its neighbour held. A cell beyond the terminator length always
  // reports a hit, so the AND of all hits is the terminator test.
  logic [BYTE_W-1:0] chain [TERM_MAX];
  logic [TERM_MAX-1:0] hits;

  for (genvar i = 0; i < TERM_MAX; i++) begin : g_cell
    localparam logic [TLEN_W-1:0] CELL_IDX = TLEN_W'(i);
    logic [BYTE_W-1:0] cell_in;
    if (i == 0) begin : g_head
      assign cell_in = s_tdata;
    end else begin : g_body
      assign cell_in = chain[i-1];
    end
    tfr_cell u_cell (
      .clk       (clk),
      .shift     (accept && is_byte),
      .enable    (CELL_IDX < term_n),
      .term_byte (term_bytes[BYTE_W*i +: BYTE_W]),
      .byte_in   (cell_in),
      .byte_out  (chain[i]),
      .hit       (hits[i])
    );
  end

  // Saturating increments.
  logic [POS_W-1:0]   frame_inc;
  logic [IDLE_W-1:0]  idle_inc;
  logic [RETRY_W-1:0] retry_inc;
  assign frame_inc = (frame_count == POS_SAT)   ? frame_count : frame_count + 1'b1;
  assign idle_inc  = (idle_count == IDLE_SAT)   ? idle_count  : idle_count + 1'b1;
  assign retry_inc = (retry_count == RETRY_SAT) ? retry_count : retry_count + 1'b1;

  // Result and next state for the transaction on the input.
  always_comb begin
    frame_count_next = frame_count;
    idle_count_next  = idle_count;
    retry_count_next = retry_count;
    res_valid        = 1'b0;
    res.status       = ST_IN_FRAME;
    res.data         = '0;
    res.position     = frame_count;
    if (is_byte) begin
      res_valid        = 1'b1;
      res.data         = s_tdata;
      res.position     = frame_inc;
      frame_count_next = frame_inc;
      idle_count_next  = '0;
      retry_count_next = '0;
      if (term_n == '0) begin
        res.status = ST_NO_TERM;
      end else if ((frame_inc >= POS_W'(term_n)) && (&hits)) begin
        res.status = ST_TERM;
      end else if (frame_inc >= max_frame_len) begin
        res.status = ST_FULL;
      end
    end else begin
      idle_count_next = idle_inc;
      if (retry_count >= retry_limit) begin
        res_valid        = 1'b1;
        res.status       = ST_DISCONN;
        retry_count_next = '0;
      end else if (idle_inc >= timeout_limit) begin
        res_valid        = 1'b1;
        res.status       = ST_TIMEOUT;
        retry_count_next = retry_inc;
        idle_count_next  = '0;
      end
    end
    res.last = (res.status != ST_IN_FRAME);
    // Any frame end starts the next frame from zero.
    if (res_valid && res.last) begin
      frame_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      idle_count  <= '0;
      retry_count <= '0;
    end else if (accept) begin
      frame_count <= frame_count_next;
      idle_count  <= idle_count_next;
      retry_count <= retry_count_next;
    end
  end

  tfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && res_valid),
    .in_ready  (buf_ready),
    .in_item   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {out_item.position, out_item.data};
  assign m_tuser = out_item.status;
  assign m_tlast = out_item.last;

endmodule

/* rtl/tfr_cell.sv */
// ---------------------------------------------------------------------------
// Terminated frame receiver history cell
// Holds one byte of the receive history, hands it on to the next cell when a
// byte arrives and compares its incoming byte with one terminator byte.
// ---------------------------------------------------------------------------
module tfr_cell
  import tfr_pkg::*;
(
  input  logic              clk,
  input  logic              shift,     // a byte transaction is taken
  input  logic              enable,    // this cell lies within the terminator
  input  logic [BYTE_W-1:0] term_byte,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [BYTE_W-1:0] byte_out,
  output logic              hit
);

  logic [BYTE_W-1:0] hist;

  always_ff @(posedge clk) begin
    if (shift) begin
      hist <= byte_in;
    end
  end

  // The byte moving into this cell is the one that stands here after the
  // shift, so it is the one compared.
  assign hit      = !enable || (byte_in == term_byte);
  assign byte_out = hist;

endmodule

/* rtl/tfr_skid.sv */
// ---------------------------------------------------------------------------
// Terminated frame receiver output buffer
// Output register with a skid stage, so the input side keeps flowing while a
// result waits on the master side.
// ---------------------------------------------------------------------------
module tfr_skid
  import tfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  logic    skid_valid;
  result_t skid_item;
  logic    pop;
  logic    push;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_item <= skid_item;
        if (push) begin
          skid_item <= in_item;
        end
      end else if (push) begin
        out_item <= in_item;
      end
    end else if (push) begin
      skid_item <= in_item;
    end
  end

endmodule
